[rtl/dht_pkg.sv]
// Shared types, constants and the wait timing table of the single-wire sensor reader.
package dht_pkg;

    localparam int DATA_BYTES = 5;
    localparam int DATA_BITS  = 8 * DATA_BYTES;
    localparam int BIT_IDX_W  = $clog2(DATA_BITS + 1);
    localparam int TICK_W     = 16;
    localparam int THRESH_W   = 7;
    localparam int WAIT_W     = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [TICK_W-1:0]   START_LOW_RESET = 16'd30000;
    localparam logic [THRESH_W-1:0] ONE_THRESH_RESET = 7'd45;

    typedef enum logic [0:0] {
        REG_START_LOW  = 1'b0,
        REG_ONE_THRESH = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_START    = 3'd1,
        PH_ACK      = 3'd2,
        PH_RESP     = 3'd3,
        PH_RDY_LOW  = 3'd4,
        PH_RDY_HIGH = 3'd5,
        PH_BIT_LOW  = 3'd6,
        PH_BIT_HIGH = 3'd7
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]   start_low_ticks;
        logic [THRESH_W-1:0] one_threshold;
    } cfg_t;

    typedef struct packed {
        logic              target;
        logic [WAIT_W-1:0] cap;
        logic [WAIT_W-1:0] min_ok;
    } wait_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       error;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temp_int;
        logic [7:0] temp_frac;
    } result_t;

    // awaited level, counter cap, lowest good duration for each wait phase
    function automatic wait_t wait_spec(input phase_t ph);
        wait_t w;
        case (ph)
            PH_ACK:      w = '{target: 1'b1, cap: 7'd10, min_ok: 7'd0};
            PH_RESP:     w = '{target: 1'b0, cap: 7'd45, min_ok: 7'd6};
            PH_RDY_LOW:  w = '{target: 1'b1, cap: 7'd90, min_ok: 7'd71};
            PH_RDY_HIGH: w = '{target: 1'b0, cap: 7'd95, min_ok: 7'd76};
            PH_BIT_LOW:  w = '{target: 1'b1, cap: 7'd65, min_ok: 7'd46};
            PH_BIT_HIGH: w = '{target: 1'b0, cap: 7'd80, min_ok: 7'd11};
            default:     w = '{target: 1'b1, cap: 7'd10, min_ok: 7'd0};
        endcase
        return w;
    endfunction

endpackage

[rtl/dht_if.sv]
// Valid/ready channel interfaces for line samples and reader results.
interface dht_sample_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, start_req, line_level, input ready);
    modport sink   (input valid, start_req, line_level, output ready);
endinterface

interface dht_result_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;

    modport source (output valid, drive_low, busy_res, done_res, error, humidity_int,
                    humidity_frac, temp_int, temp_frac, input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, error, humidity_int,
                    humidity_frac, temp_int, temp_frac, output ready);
endinterface

[rtl/dht_cfg.sv]
// APB-style register file holding the start pulse length and the one-bit threshold.
module dht_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dht_pkg::PADDR_W-1:0]  paddr,
    input  logic [dht_pkg::PDATA_W-1:0]  pwdata,
    output logic [dht_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output dht_pkg::cfg_t                cfg
);

    dht_pkg::cfg_t     cfg_reg;
    dht_pkg::reg_idx_t sel_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign sel_idx = dht_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= dht_pkg::START_LOW_RESET;
            cfg_reg.one_threshold   <= dht_pkg::ONE_THRESH_RESET;
        end
        else if (wr_en)
        begin
            case (sel_idx)
                dht_pkg::REG_START_LOW:
                    cfg_reg.start_low_ticks <= pwdata[dht_pkg::TICK_W-1:0];
                dht_pkg::REG_ONE_THRESH:
                    cfg_reg.one_threshold <= pwdata[dht_pkg::THRESH_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (sel_idx)
            dht_pkg::REG_START_LOW:
                prdata = {{(dht_pkg::PDATA_W-dht_pkg::TICK_W){1'b0}}, cfg_reg.start_low_ticks};
            dht_pkg::REG_ONE_THRESH:
                prdata = {{(dht_pkg::PDATA_W-dht_pkg::THRESH_W){1'b0}}, cfg_reg.one_threshold};
            default:
                prdata = '0;
        endcase
    end

endmodule

[rtl/dht_core.sv]
// Per-tick phase sequencer, wait timer, bit shifter and registered result stage.
module dht_core (
    input  logic          clk,
    input  logic          rst_n,
    input  dht_pkg::cfg_t cfg,
    dht_sample_if.sink    sample,
    dht_result_if.source  result
);

    dht_pkg::phase_t                 phase_reg, phase_next;
    logic [dht_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [dht_pkg::BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [dht_pkg::DATA_BITS-1:0]   shift_reg, shift_next;
    logic                            err_reg, err_next;
    dht_pkg::result_t                result_reg, result_next;
    logic                            out_valid_reg;

    dht_pkg::wait_t                  spec;
    logic [dht_pkg::TICK_W-1:0]      tick_inc;
    logic [dht_pkg::TICK_W-1:0]      cap_w;
    logic [dht_pkg::TICK_W-1:0]      dur;
    logic                            ended;
    logic                            done;
    logic [7:0]                      sum;
    logic                            accept;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = !out_valid_reg || result.ready;
    assign spec         = dht_pkg::wait_spec(phase_reg);
    assign tick_inc     = tick_reg + 1'b1;
    assign cap_w        = {{(dht_pkg::TICK_W-dht_pkg::WAIT_W){1'b0}}, spec.cap};

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        err_next     = err_reg;
        done         = 1'b0;
        ended        = 1'b0;
        dur          = '0;
        sum          = '0;
        case (phase_reg)
            dht_pkg::PH_IDLE:
            begin
                if (sample.start_req)
                begin
                    phase_next   = dht_pkg::PH_START;
                    tick_next    = '0;
                    bit_idx_next = '0;
                    err_next     = 1'b0;
                end
            end
            dht_pkg::PH_START:
            begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.start_low_ticks)
                begin
                    phase_next = dht_pkg::PH_ACK;
                    tick_next  = '0;
                end
            end
            default:
            begin
                if (sample.line_level == spec.target)
                begin
                    ended = 1'b1;
                    dur   = tick_reg;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cap_w)
                    begin
                        ended = 1'b1;
                        dur   = cap_w;
                    end
                end
                if (ended)
                begin
                    if (dur >= cap_w ||
                        dur < {{(dht_pkg::TICK_W-dht_pkg::WAIT_W){1'b0}}, spec.min_ok})
                    begin
                        err_next = 1'b1;
                    end
                    tick_next = '0;
                    if (phase_reg == dht_pkg::PH_BIT_HIGH)
                    begin
                        shift_next = {shift_reg[dht_pkg::DATA_BITS-2:0],
                                      dur > {{(dht_pkg::TICK_W-dht_pkg::THRESH_W){1'b0}},
                                             cfg.one_threshold}};
                        bit_idx_next = bit_idx_reg + 1'b1;
                        if (bit_idx_next >= dht_pkg::BIT_IDX_W'(dht_pkg::DATA_BITS))
                        begin
                            sum = shift_next[39:32] + shift_next[31:24]
                                + shift_next[23:16] + shift_next[15:8];
                            if (shift_next[7:0] != sum)
                            begin
                                err_next = 1'b1;
                            end
                            phase_next = dht_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = dht_pkg::PH_BIT_LOW;
                        end
                    end
                    else
                    begin
                        phase_next = dht_pkg::phase_t'(phase_reg + 3'd1);
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        result_next.drive_low     = (phase_next == dht_pkg::PH_START);
        result_next.busy_res      = (phase_next != dht_pkg::PH_IDLE);
        result_next.done_res      = done;
        result_next.error         = err_next;
        result_next.humidity_int  = shift_next[39:32];
        result_next.humidity_frac = shift_next[31:24];
        result_next.temp_int      = shift_next[23:16];
        result_next.temp_frac     = shift_next[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dht_pkg::PH_IDLE;
            tick_reg      <= '0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_idx_reg   <= bit_idx_next;
                shift_reg     <= shift_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.drive_low     = result_reg.drive_low;
    assign result.busy_res      = result_reg.busy_res;
    assign result.done_res      = result_reg.done_res;
    assign result.error         = result_reg.error;
    assign result.humidity_int  = result_reg.humidity_int;
    assign result.humidity_frac = result_reg.humidity_frac;
    assign result.temp_int      = result_reg.temp_int;
    assign result.temp_frac     = result_reg.temp_frac;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.done_res) |-> !result_reg.busy_res)
        else $error("done beat while still busy");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.drive_low) |-> result_reg.busy_res)
        else $error("line driven low while not busy");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= dht_pkg::BIT_IDX_W'(dht_pkg::DATA_BITS))
        else $error("bit index past last data bit");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == dht_pkg::PH_IDLE && sample.start_req)
        |=> (phase_reg == dht_pkg::PH_START && !err_reg))
        else $error("start request not taken while idle");

    a_wait_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != dht_pkg::PH_IDLE && phase_reg != dht_pkg::PH_START)
        |-> tick_reg < cap_w)
        else $error("wait timer beyond its cap");

endmodule

[rtl/dht11_sensor_reader.sv]
// Top level of the single-wire humidity and temperature sensor reader.
// A result beat is registered and is valid in the cycle after its sample beat is accepted.
// Throughput: one sample beat per cycle unless an untaken result stalls it; the
// result register takes a new sample while the old result is taken in the same cycle.
// Reset (async, active low) returns to idle, clears timer, bit count, data and error,
// and loads the register defaults (start pulse 30000 ticks, one threshold 45).
module dht11_sensor_reader (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dht_pkg::PADDR_W-1:0]  paddr,
    input  logic [dht_pkg::PDATA_W-1:0]  pwdata,
    output logic [dht_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    dht_sample_if.sink                   sample,
    dht_result_if.source                 result
);

    dht_pkg::cfg_t cfg;

    dht_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dht_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .result (result)
    );

endmodule
